// File: rtl/mrrb_pkg.sv
package mrrb_pkg;

  localparam int unsigned BUF_WORDS        = 1024;
  localparam int unsigned MAX_RECORD_WORDS = 64;
  localparam int unsigned NUM_CHANNELS     = 16;

  localparam int unsigned ADDR_W   = $clog2(BUF_WORDS);
  localparam int unsigned PTR_W    = $clog2(BUF_WORDS + 1);
  localparam int unsigned OP_W     = 3;
  localparam int unsigned CH_W     = 4;
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FREE_W   = 11;

  // header word layout
  localparam int unsigned HDR_PEND_BIT = 31;
  localparam int unsigned HDR_LEN_LSB  = 4;
  localparam int unsigned HDR_CH_LSB   = 0;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [CH_W-1:0]   ch_t;

  typedef enum logic [OP_W-1:0] {
    OP_BEGIN = 3'd0,
    OP_STORE = 3'd1,
    OP_FETCH = 3'd2,
    OP_INVAL = 3'd3,
    OP_CLEAR = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_NOROOM = 2'd1,
    ST_NONE   = 2'd2,
    ST_SEQ    = 2'd3
  } status_e;

  function automatic word_t make_hdr(logic pend, len_t len, ch_t ch);
    word_t h;
    h = '0;
    h[HDR_PEND_BIT] = pend;
    h[HDR_LEN_LSB +: LEN_W] = len;
    h[HDR_CH_LSB +: CH_W] = ch;
    return h;
  endfunction

endpackage

// File: rtl/mrrb_in_if.sv
interface mrrb_in_if;
  logic                           valid;
  logic                           ready;
  logic [mrrb_pkg::OP_W-1:0]      operation;
  logic [mrrb_pkg::CH_W-1:0]      channel;
  logic [mrrb_pkg::LEN_W-1:0]     length_words;
  logic [mrrb_pkg::WORD_W-1:0]    data_word;

  modport source (
    output valid, operation, channel, length_words, data_word,
    input  ready
  );
  modport sink (
    input  valid, operation, channel, length_words, data_word,
    output ready
  );
endinterface

// File: rtl/mrrb_out_if.sv
interface mrrb_out_if;
  logic                           valid;
  logic                           ready;
  logic [mrrb_pkg::STATUS_W-1:0]  status;
  logic [mrrb_pkg::WORD_W-1:0]    payload_word;
  logic                           payload_valid;
  logic                           last;
  logic [mrrb_pkg::FREE_W-1:0]    free_space;

  modport source (
    output valid, status, payload_word, payload_valid, last, free_space,
    input  ready
  );
  modport sink (
    input  valid, status, payload_word, payload_valid, last, free_space,
    output ready
  );
endinterface

// File: rtl/mrrb_ram.sv
module mrrb_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/mrrb_space.sv
module mrrb_space (
  input  mrrb_pkg::ptr_t rd_ptr_i,
  input  mrrb_pkg::ptr_t wr_ptr_i,
  input  mrrb_pkg::ptr_t wrap_end_i,
  output mrrb_pkg::ptr_t free_o
);

  mrrb_pkg::ptr_t tail;

  always_comb begin
    tail = mrrb_pkg::PTR_W'(mrrb_pkg::BUF_WORDS) - wr_ptr_i;
    if (wrap_end_i == '0) begin
      // larger of the gap at the start and the tail after the write pointer
      free_o = (rd_ptr_i > tail) ? rd_ptr_i : tail;
    end else begin
      free_o = (rd_ptr_i >= wr_ptr_i) ? (rd_ptr_i - wr_ptr_i) : '0;
    end
  end

endmodule

// File: rtl/multichannel_record_ring_buffer.sv
// order: begin_store, store_data, clear and unknown codes go through exec and finish
// before the answer, a store_data closing a record also through the header write; fetch
// and invalidate walk one header a cycle, then each fetched word is loaded and sent
// throughput: one request at a time, the walk reads one word a cycle through the single
// registered read port of the record memory; each payload word waits on the receiver
// reset: pointers, wrap mark and open store cleared at once; record memory is not cleared
module multichannel_record_ring_buffer (
  input  logic              clk_i,
  input  logic              rst_ni,
  mrrb_in_if.sink           req_i,
  mrrb_out_if.source        rsp_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_HDRW,
    S_WALK,
    S_LOAD,
    S_FIN,
    S_SEND
  } state_e;

  localparam int unsigned PTR_W  = mrrb_pkg::PTR_W;
  localparam int unsigned ADDR_W = mrrb_pkg::ADDR_W;
  localparam int unsigned LEN_W  = mrrb_pkg::LEN_W;

  state_e state_q, state_d;

  // latched request
  logic [mrrb_pkg::OP_W-1:0] op_q, op_d;
  mrrb_pkg::ch_t             ch_q, ch_d;
  mrrb_pkg::len_t            len_in_q, len_in_d;
  mrrb_pkg::word_t           dw_q, dw_d;

  // ring state
  mrrb_pkg::ptr_t rd_ptr_q, rd_ptr_d;
  mrrb_pkg::ptr_t wr_ptr_q, wr_ptr_d;
  mrrb_pkg::ptr_t wrap_end_q, wrap_end_d;
  mrrb_pkg::len_t words_left_q, words_left_d;
  mrrb_pkg::len_t open_len_q, open_len_d;
  mrrb_pkg::ch_t  open_ch_q, open_ch_d;

  // walk and payload sequencer state
  mrrb_pkg::ptr_t   p_q, p_d;
  logic             upd_q, upd_d;
  mrrb_pkg::ptr_t   guard_q, guard_d;
  mrrb_pkg::ptr_t   start_q, start_d;
  mrrb_pkg::len_t   rec_len_q, rec_len_d;
  mrrb_pkg::len_t   idx_q, idx_d;
  mrrb_pkg::status_e status_q, status_d;

  // output register
  mrrb_pkg::status_e           out_status_q, out_status_d;
  mrrb_pkg::word_t             out_word_q, out_word_d;
  logic                        out_pv_q, out_pv_d;
  logic                        out_last_q, out_last_d;
  logic [mrrb_pkg::FREE_W-1:0] out_free_q, out_free_d;

  // record memory port
  logic            ram_we, ram_re;
  mrrb_pkg::addr_t ram_waddr, ram_raddr;
  mrrb_pkg::word_t ram_wdata, ram_rdata;

  mrrb_pkg::ptr_t free_words;

  // header decode and next-record arithmetic of the walk
  logic             h_oob, h_pend, h_bad, h_match;
  mrrb_pkg::len_t   h_len;
  mrrb_pkg::ch_t    h_ch;
  logic [PTR_W:0]   np_wide;
  mrrb_pkg::ptr_t   np, p_next;
  logic             upd_next;

  // begin_store checks
  logic [LEN_W:0]   rec_size;
  logic             bs_seq, bs_long, bs_full, bs_wrap;
  logic [PTR_W:0]   wr_plus_size;
  logic [PTR_W:0]   store_idx;
  logic [PTR_W:0]   pay_addr;

  mrrb_ram #(
    .DEPTH (mrrb_pkg::BUF_WORDS),
    .WIDTH (mrrb_pkg::WORD_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  mrrb_space u_space (
    .rd_ptr_i   (rd_ptr_q),
    .wr_ptr_i   (wr_ptr_q),
    .wrap_end_i (wrap_end_q),
    .free_o     (free_words)
  );

  assign req_i.ready         = (state_q == S_IDLE);
  assign rsp_o.valid         = (state_q == S_SEND);
  assign rsp_o.status        = out_status_q;
  assign rsp_o.payload_word  = out_word_q;
  assign rsp_o.payload_valid = out_pv_q;
  assign rsp_o.last          = out_last_q;
  assign rsp_o.free_space    = out_free_q;

  // header at the walk position, a position past the ring end reads as an empty header
  always_comb begin
    h_oob   = (p_q >= PTR_W'(mrrb_pkg::BUF_WORDS));
    h_len   = h_oob ? '0 : ram_rdata[mrrb_pkg::HDR_LEN_LSB +: LEN_W];
    h_pend  = !h_oob && ram_rdata[mrrb_pkg::HDR_PEND_BIT];
    h_ch    = ram_rdata[mrrb_pkg::HDR_CH_LSB +: mrrb_pkg::CH_W];
    np_wide = {1'b0, p_q} + (PTR_W+1)'(h_len) + (PTR_W+1)'(1);
    // a zero length or a record running off the ring end stops the walk
    h_bad   = (h_len == '0) || (np_wide > (PTR_W+1)'(mrrb_pkg::BUF_WORDS));
    np      = np_wide[PTR_W-1:0];
    h_match = h_pend && (h_ch == ch_q);
  end

  // begin_store room and sequence checks
  always_comb begin
    rec_size     = {1'b0, len_in_q} + (LEN_W+1)'(1);
    bs_seq       = (words_left_q != '0) || (len_in_q == '0) ||
                   (32'(ch_q) >= mrrb_pkg::NUM_CHANNELS);
    bs_long      = (32'(len_in_q) > mrrb_pkg::MAX_RECORD_WORDS);
    bs_full      = (PTR_W'(rec_size) > free_words);
    wr_plus_size = {1'b0, wr_ptr_q} + (PTR_W+1)'(rec_size);
    bs_wrap      = (wr_plus_size > (PTR_W+1)'(mrrb_pkg::BUF_WORDS));
    // next payload slot of the open record
    store_idx    = {1'b0, wr_ptr_q} + (PTR_W+1)'(open_len_q) + (PTR_W+1)'(1)
                   - (PTR_W+1)'(words_left_q);
    pay_addr     = {1'b0, start_q} + (PTR_W+1)'(idx_q) + (PTR_W+1)'(1);
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    ch_d         = ch_q;
    len_in_d     = len_in_q;
    dw_d         = dw_q;
    rd_ptr_d     = rd_ptr_q;
    wr_ptr_d     = wr_ptr_q;
    wrap_end_d   = wrap_end_q;
    words_left_d = words_left_q;
    open_len_d   = open_len_q;
    open_ch_d    = open_ch_q;
    p_d          = p_q;
    upd_d        = upd_q;
    guard_d      = guard_q;
    start_d      = start_q;
    rec_len_d    = rec_len_q;
    idx_d        = idx_q;
    status_d     = status_q;
    out_status_d = out_status_q;
    out_word_d   = out_word_q;
    out_pv_d     = out_pv_q;
    out_last_d   = out_last_q;
    out_free_d   = out_free_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = '0;
    upd_next     = upd_q;
    p_next       = np;

    case (state_q)
      S_IDLE: begin
        // take the request
        if (req_i.valid) begin
          op_d     = req_i.operation;
          ch_d     = req_i.channel;
          len_in_d = req_i.length_words;
          dw_d     = req_i.data_word;
          state_d  = S_EXEC;
        end
      end

      S_EXEC: begin
        status_d = mrrb_pkg::ST_OK;
        state_d  = S_FIN;
        case (op_q)
          mrrb_pkg::OP_BEGIN: begin
            if (bs_seq) begin
              status_d = mrrb_pkg::ST_SEQ;
            end else if (bs_long || bs_full || (bs_wrap && (wrap_end_q != '0))) begin
              status_d = mrrb_pkg::ST_NOROOM;
            end else begin
              // open the record, wrapping to the ring start when the tail is short
              ram_we    = 1'b1;
              ram_wdata = mrrb_pkg::make_hdr(1'b0, len_in_q, ch_q);
              if (bs_wrap) begin
                wrap_end_d = wr_ptr_q;
                wr_ptr_d   = '0;
                ram_waddr  = '0;
              end else begin
                ram_waddr  = wr_ptr_q[ADDR_W-1:0];
              end
              words_left_d = len_in_q;
              open_len_d   = len_in_q;
              open_ch_d    = ch_q;
            end
          end

          mrrb_pkg::OP_STORE: begin
            if (words_left_q == '0) begin
              status_d = mrrb_pkg::ST_SEQ;
            end else begin
              ram_we       = 1'b1;
              ram_waddr    = store_idx[ADDR_W-1:0];
              ram_wdata    = dw_q;
              words_left_d = words_left_q - LEN_W'(1);
              // last word: header gets its pending bit next cycle
              if (words_left_q == LEN_W'(1)) begin
                state_d = S_HDRW;
              end
            end
          end

          mrrb_pkg::OP_FETCH, mrrb_pkg::OP_INVAL: begin
            if ((rd_ptr_q == wr_ptr_q) && (wrap_end_q == '0)) begin
              // ring empty
              status_d = (op_q == mrrb_pkg::OP_FETCH) ? mrrb_pkg::ST_NONE
                                                      : mrrb_pkg::ST_OK;
            end else begin
              p_d       = rd_ptr_q;
              upd_d     = 1'b1;
              guard_d   = '0;
              ram_re    = 1'b1;
              ram_raddr = rd_ptr_q[ADDR_W-1:0];
              state_d   = S_WALK;
            end
          end

          mrrb_pkg::OP_CLEAR: begin
            rd_ptr_d     = '0;
            wr_ptr_d     = '0;
            wrap_end_d   = '0;
            words_left_d = '0;
          end

          default: begin
            status_d = mrrb_pkg::ST_SEQ;
          end
        endcase
      end

      S_HDRW: begin
        // record complete: mark pending and move the write pointer past it
        ram_we    = 1'b1;
        ram_waddr = wr_ptr_q[ADDR_W-1:0];
        ram_wdata = mrrb_pkg::make_hdr(1'b1, open_len_q, open_ch_q);
        wr_ptr_d  = wr_ptr_q + PTR_W'(open_len_q) + PTR_W'(1);
        state_d   = S_FIN;
      end

      S_WALK: begin
        // one record header per cycle, ram_rdata holds the header at p_q
        if (h_bad) begin
          status_d = (op_q == mrrb_pkg::OP_FETCH) ? mrrb_pkg::ST_NONE : mrrb_pkg::ST_OK;
          state_d  = S_FIN;
        end else if (op_q == mrrb_pkg::OP_FETCH) begin
          if (h_match) begin
            // found: consume the header, settle the pointers, then stream payload
            ram_we    = 1'b1;
            ram_waddr = p_q[ADDR_W-1:0];
            ram_wdata = mrrb_pkg::make_hdr(1'b0, h_len, h_ch);
            if (upd_q) begin
              if ((np == wr_ptr_q) && (wrap_end_q == '0)) begin
                if (words_left_q == '0) begin
                  rd_ptr_d = '0;
                  wr_ptr_d = '0;
                end else begin
                  rd_ptr_d = np;
                end
              end else if (np == wrap_end_q) begin
                rd_ptr_d   = '0;
                wrap_end_d = '0;
              end else begin
                rd_ptr_d = np;
              end
            end
            start_d   = p_q + PTR_W'(1);
            rec_len_d = h_len;
            idx_d     = '0;
            ram_re    = 1'b1;
            ram_raddr = ADDR_W'(p_q + PTR_W'(1));
            status_d  = mrrb_pkg::ST_OK;
            state_d   = S_LOAD;
          end else begin
            // a pending record of another channel pins the read pointer
            upd_next = upd_q && !h_pend;
            if (np == wrap_end_q) begin
              p_next = '0;
              if (upd_next) begin
                rd_ptr_d   = '0;
                wrap_end_d = '0;
              end
            end
            upd_d = upd_next;
            if ((p_next == wr_ptr_q) || (guard_q == PTR_W'(mrrb_pkg::BUF_WORDS))) begin
              status_d = mrrb_pkg::ST_NONE;
              state_d  = S_FIN;
            end else begin
              p_d       = p_next;
              guard_d   = guard_q + PTR_W'(1);
              ram_re    = 1'b1;
              ram_raddr = p_next[ADDR_W-1:0];
            end
          end
        end else begin
          // invalidate: clear matching records, drop leading consumed ones
          status_d = mrrb_pkg::ST_OK;
          if (h_match) begin
            ram_we    = 1'b1;
            ram_waddr = p_q[ADDR_W-1:0];
            ram_wdata = mrrb_pkg::make_hdr(1'b0, h_len, h_ch);
          end
          upd_next = upd_q && !(h_pend && !h_match);
          upd_d    = upd_next;
          if (upd_next && (np == wr_ptr_q) && (wrap_end_q == '0)) begin
            // ring fully read
            if (words_left_q == '0) begin
              rd_ptr_d = '0;
              wr_ptr_d = '0;
            end else begin
              rd_ptr_d = np;
            end
            state_d = S_FIN;
          end else begin
            if (np == wrap_end_q) begin
              p_next = '0;
              if (upd_next) begin
                rd_ptr_d   = '0;
                wrap_end_d = '0;
              end
            end else if (upd_next) begin
              rd_ptr_d = np;
            end
            if ((p_next == wr_ptr_q) || (guard_q == PTR_W'(mrrb_pkg::BUF_WORDS))) begin
              state_d = S_FIN;
            end else begin
              p_d       = p_next;
              guard_d   = guard_q + PTR_W'(1);
              ram_re    = 1'b1;
              ram_raddr = p_next[ADDR_W-1:0];
            end
          end
        end
      end

      S_LOAD: begin
        // payload word from the read issued last cycle
        out_status_d = mrrb_pkg::ST_OK;
        out_word_d   = ram_rdata;
        out_pv_d     = 1'b1;
        out_last_d   = (({1'b0, idx_q} + (LEN_W+1)'(1)) == {1'b0, rec_len_q});
        out_free_d   = mrrb_pkg::FREE_W'(free_words);
        state_d      = S_SEND;
      end

      S_FIN: begin
        // single result of the request
        out_status_d = status_q;
        out_word_d   = '0;
        out_pv_d     = 1'b0;
        out_last_d   = 1'b1;
        out_free_d   = mrrb_pkg::FREE_W'(free_words);
        state_d      = S_SEND;
      end

      S_SEND: begin
        if (rsp_o.ready) begin
          if (out_pv_q && !out_last_q) begin
            idx_d     = idx_q + LEN_W'(1);
            ram_re    = 1'b1;
            ram_raddr = pay_addr[ADDR_W-1:0];
            state_d   = S_LOAD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= '0;
      ch_q         <= '0;
      len_in_q     <= '0;
      dw_q         <= '0;
      rd_ptr_q     <= '0;
      wr_ptr_q     <= '0;
      wrap_end_q   <= '0;
      words_left_q <= '0;
      open_len_q   <= '0;
      open_ch_q    <= '0;
      p_q          <= '0;
      upd_q        <= 1'b0;
      guard_q      <= '0;
      start_q      <= '0;
      rec_len_q    <= '0;
      idx_q        <= '0;
      status_q     <= mrrb_pkg::ST_OK;
      out_status_q <= mrrb_pkg::ST_OK;
      out_word_q   <= '0;
      out_pv_q     <= 1'b0;
      out_last_q   <= 1'b0;
      out_free_q   <= '0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      ch_q         <= ch_d;
      len_in_q     <= len_in_d;
      dw_q         <= dw_d;
      rd_ptr_q     <= rd_ptr_d;
      wr_ptr_q     <= wr_ptr_d;
      wrap_end_q   <= wrap_end_d;
      words_left_q <= words_left_d;
      open_len_q   <= open_len_d;
      open_ch_q    <= open_ch_d;
      p_q          <= p_d;
      upd_q        <= upd_d;
      guard_q      <= guard_d;
      start_q      <= start_d;
      rec_len_q    <= rec_len_d;
      idx_q        <= idx_d;
      status_q     <= status_d;
      out_status_q <= out_status_d;
      out_word_q   <= out_word_d;
      out_pv_q     <= out_pv_d;
      out_last_q   <= out_last_d;
      out_free_q   <= out_free_d;
    end
  end

endmodule

// File: dv/multichannel_record_ring_buffer_tb.sv
module multichannel_record_ring_buffer_tb;
  import mrrb_pkg::*;

  // cycles with no handshake on either side before the run is declared hung
  // (longest fetch walk ~512 headers, plus the receiver hold-off and stalls)
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES    = 20;
  localparam int unsigned HOLD_OFF_LEN   = 300;
  localparam int unsigned RANDOM_REQS    = 200;

  // operation codes the block does not define
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  typedef struct packed {
    status_e             status;
    word_t               payload;
    logic                pvalid;
    logic                last;
    logic [FREE_W-1:0]   room;
  } resp_t;

  logic clk_i;
  logic rst_ni;

  mrrb_in_if  req_if ();
  mrrb_out_if rsp_if ();

  multichannel_record_ring_buffer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // ring image: record words, read/write pointers, wrap mark, words still owed
  word_t       ring_mem [BUF_WORDS];
  int unsigned rd_ptr;
  int unsigned wr_ptr;
  int unsigned wrap_mark;
  int unsigned open_left;

  // responses the ring owes, oldest first
  resp_t ring_answers_q [$];

  int unsigned fail_count;
  int unsigned reqs_sent;
  int unsigned quiet_cycles;
  bit          send_idle_on;
  bit          recv_idle_on;
  int unsigned hold_off_len;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // ring behavior
  // ---------------------------------------------------------------------------

  // words free for the next record: whole tail or head when not wrapped,
  // the gap up to the read pointer when wrapped
  function automatic int unsigned ring_room();
    int unsigned tail;
    if (wrap_mark == 0) begin
      tail = (wr_ptr <= BUF_WORDS) ? BUF_WORDS - wr_ptr : 0;
      return (rd_ptr > tail) ? rd_ptr : tail;
    end
    return (rd_ptr >= wr_ptr) ? rd_ptr - wr_ptr : 0;
  endfunction

  function automatic word_t peek(int unsigned a);
    return (a < BUF_WORDS) ? ring_mem[a] : '0;
  endfunction

  // everything read: empty the ring unless a record is still being written
  function automatic void ring_drained(int unsigned p);
    if (open_left == 0) begin
      rd_ptr = 0;
      wr_ptr = 0;
    end else begin
      rd_ptr = p;
    end
  endfunction

  // walk to the first pending record of the channel and take its payload
  function automatic void fetch_record(ch_t ch, ref word_t words[$]);
    int unsigned p, len, start, g, i;
    word_t       h;
    bit          upd;
    upd = 1'b1;
    words.delete();
    if (rd_ptr == wr_ptr && wrap_mark == 0) return;
    p = rd_ptr;
    for (g = 0; g <= BUF_WORDS; g++) begin
      h   = peek(p);
      len = h[HDR_LEN_LSB +: LEN_W];
      if (len == 0 || p + 1 + len > BUF_WORDS) return;
      start = p + 1;
      p += 1 + len;
      if (h[HDR_PEND_BIT]) begin
        if (h[HDR_CH_LSB +: CH_W] == ch) begin
          for (i = 0; i < len; i++) words.push_back(ring_mem[start + i]);
          ring_mem[start - 1][HDR_PEND_BIT] = 1'b0;
          // read pointer only moves while nothing pending lies in front
          if (upd) begin
            if (p == wr_ptr && wrap_mark == 0) begin
              ring_drained(p);
            end else if (p == wrap_mark) begin
              rd_ptr    = 0;
              wrap_mark = 0;
            end else begin
              rd_ptr = p;
            end
          end
          return;
        end
        upd = 1'b0;
      end
      if (p == wrap_mark) begin
        if (upd) begin
          rd_ptr    = 0;
          wrap_mark = 0;
        end
        p = 0;
      end
      if (p == wr_ptr) return;
    end
  endfunction

  // drop the pending mark of every record of the channel
  function automatic void invalidate_channel(ch_t ch);
    int unsigned p, len, g;
    word_t       h;
    bit          upd;
    upd = 1'b1;
    if (rd_ptr == wr_ptr && wrap_mark == 0) return;
    p = rd_ptr;
    for (g = 0; g <= BUF_WORDS; g++) begin
      h   = peek(p);
      len = h[HDR_LEN_LSB +: LEN_W];
      if (len == 0 || p + 1 + len > BUF_WORDS) return;
      if (h[HDR_PEND_BIT]) begin
        if (h[HDR_CH_LSB +: CH_W] == ch) ring_mem[p][HDR_PEND_BIT] = 1'b0;
        else upd = 1'b0;
      end
      p += 1 + len;
      if (upd) begin
        if (p == wr_ptr && wrap_mark == 0) begin
          ring_drained(p);
          return;
        end else if (p == wrap_mark) begin
          p         = 0;
          rd_ptr    = 0;
          wrap_mark = 0;
        end else begin
          rd_ptr = p;
        end
      end else if (p == wrap_mark) begin
        p = 0;
      end
      if (p == wr_ptr) return;
    end
  endfunction

  function automatic status_e open_record(ch_t ch, len_t len);
    int unsigned size;
    word_t       h;
    size = len + 1;
    if (open_left != 0 || len == 0 || ch >= NUM_CHANNELS) return ST_SEQ;
    if (len > MAX_RECORD_WORDS || size > ring_room()) return ST_NOROOM;
    // no fit before the end: mark the wrap and start over at word 0
    if (wr_ptr + size > BUF_WORDS) begin
      if (wrap_mark != 0) return ST_NOROOM;
      wrap_mark = wr_ptr;
      wr_ptr    = 0;
    end
    h = '0;
    h[HDR_LEN_LSB +: LEN_W] = len;
    h[HDR_CH_LSB +: CH_W]   = ch;
    ring_mem[wr_ptr] = h;
    open_left        = len;
    return ST_OK;
  endfunction

  function automatic status_e append_word(word_t w);
    int unsigned len, idx;
    if (open_left == 0 || wr_ptr >= BUF_WORDS) return ST_SEQ;
    len = ring_mem[wr_ptr][HDR_LEN_LSB +: LEN_W];
    idx = wr_ptr + 1 + len - open_left;
    if (idx < BUF_WORDS) ring_mem[idx] = w;
    open_left--;
    // last word arrived: record becomes visible
    if (open_left == 0) begin
      ring_mem[wr_ptr][HDR_PEND_BIT] = 1'b1;
      wr_ptr += 1 + len;
    end
    return ST_OK;
  endfunction

  // apply one accepted request and queue the responses it owes
  function automatic void apply_ring_op(logic [OP_W-1:0] op, ch_t ch, len_t len, word_t dw);
    status_e     st;
    word_t       words[$];
    int unsigned room;
    resp_t       r;
    st = ST_OK;
    case (op)
      OP_BEGIN: st = open_record(ch, len);
      OP_STORE: st = append_word(dw);
      OP_FETCH: begin
        fetch_record(ch, words);
        if (words.size() == 0) st = ST_NONE;
      end
      OP_INVAL: invalidate_channel(ch);
      OP_CLEAR: begin
        rd_ptr    = 0;
        wr_ptr    = 0;
        wrap_mark = 0;
        open_left = 0;
      end
      default: st = ST_SEQ;
    endcase
    room   = ring_room();
    r.room = room[FREE_W-1:0];
    if (words.size() == 0) begin
      r.status  = st;
      r.payload = '0;
      r.pvalid  = 1'b0;
      r.last    = 1'b1;
      ring_answers_q.push_back(r);
    end else begin
      foreach (words[k]) begin
        r.status  = ST_OK;
        r.payload = words[k];
        r.pvalid  = 1'b1;
        r.last    = (k == words.size() - 1);
        ring_answers_q.push_back(r);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // response checking and watchdog
  // ---------------------------------------------------------------------------

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    resp_t want;
    if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (ring_answers_q.size() == 0) begin
        $error("response with nothing outstanding: status %0d payload 0x%0h",
               rsp_if.status, rsp_if.payload_word);
        fail_count++;
      end else begin
        want = ring_answers_q.pop_front();
        compare_field("status", want.status, rsp_if.status);
        compare_field("payload_word", want.payload, rsp_if.payload_word);
        compare_field("payload_valid", want.pvalid, rsp_if.payload_valid);
        compare_field("last", want.last, rsp_if.last);
        compare_field("free_space", want.room, rsp_if.free_space);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("** multichannel_record_ring_buffer: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // idling and the response side
  // ---------------------------------------------------------------------------

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_gap();
    int unsigned d;
    d = $urandom_range(0, 99);
    if (d < 70) return $urandom_range(1, 2);
    if (d < 95) return $urandom_range(3, 6);
    return $urandom_range(15, 40);
  endfunction

  // receiver ready: random stalls, plus a long hold-off on request
  initial begin : rsp_ready_drive
    int unsigned hold_cnt, stall_cnt;
    hold_cnt     = 0;
    stall_cnt    = 0;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_len != 0) begin
        hold_cnt     = hold_off_len;
        hold_off_len = 0;
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        rsp_if.ready <= 1'b0;
      end else if (stall_cnt != 0) begin
        stall_cnt--;
        rsp_if.ready <= 1'b0;
      end else if (recv_idle_on && $urandom_range(0, 99) < 25) begin
        stall_cnt = idle_gap() - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // offer one request and wait for the handshake; valid stays high when the
  // next request follows without a gap
  task automatic send_req(logic [OP_W-1:0] op, ch_t ch, len_t len, word_t dw);
    int unsigned gap;
    gap = (send_idle_on && $urandom_range(0, 99) < 35) ? idle_gap() : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.operation    <= op;
    req_if.channel      <= ch;
    req_if.length_words <= len;
    req_if.data_word    <= dw;
    @(posedge clk_i);
    while (req_if.ready !== 1'b1) @(posedge clk_i);
    apply_ring_op(op, ch, len, dw);
    reqs_sent++;
  endtask

  // open a record and send all its payload
  task automatic store_record(ch_t ch, int unsigned len);
    send_req(OP_BEGIN, ch, len_t'(len), $urandom);
    repeat (len) send_req(OP_STORE, $urandom, $urandom, $urandom);
  endtask

  function automatic ch_t pick_channel();
    if ($urandom_range(0, 3) != 0) return $urandom_range(0, 3);
    return $urandom_range(0, NUM_CHANNELS - 1);
  endfunction

  function automatic len_t pick_len();
    int unsigned d;
    d = $urandom_range(0, 99);
    if (d < 70) return $urandom_range(1, 8);
    if (d < 95) return $urandom_range(9, MAX_RECORD_WORDS - 1);
    return MAX_RECORD_WORDS;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // each operation once, field extremes and the error paths
  task automatic test_single_ops();
    int unsigned c;
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    send_req(OP_FETCH, 0, 0, '0);                  // empty ring, nothing pending
    send_req(OP_INVAL, NUM_CHANNELS - 1, 0, '0);
    send_req(OP_STORE, 0, 0, 32'h1234_5678);       // no store open, word dropped
    send_req(OP_BEGIN, 1, 0, '0);                  // zero length
    send_req(OP_BEGIN, 1, MAX_RECORD_WORDS + 1, '0);
    send_req(OP_BEGIN, 1, '1, '0);                 // largest length code
    send_req(OP_BEGIN, NUM_CHANNELS - 1, 1, '0);
    send_req(OP_BEGIN, 2, 4, '0);                  // store already open
    send_req(OP_STORE, 0, 0, '1);
    send_req(OP_BEGIN, 0, 2, '0);
    send_req(OP_STORE, 0, 0, '0);
    send_req(OP_STORE, 0, 0, 32'hA5A5_5A5A);
    send_req(OP_FETCH, 3, 0, '0);                  // other channels pending only
    send_req(OP_FETCH, NUM_CHANNELS - 1, 0, '0);
    send_req(OP_FETCH, 0, 0, '0);                  // empties the ring
    for (c = OP_UNUSED_LO; c <= OP_UNUSED_HI; c++) send_req(c, '1, '1, '1);
    send_req(OP_BEGIN, 2, 3, '0);
    send_req(OP_STORE, 0, 0, $urandom);
    send_req(OP_CLEAR, 0, 0, '0);                  // abandons the open store
    send_req(OP_STORE, 0, 0, $urandom);
  endtask

  // fill to the last word while the receiver holds off, then wrap and walk
  // across the wrap mark
  task automatic test_fill_and_wrap();
    send_idle_on = 1'b0;
    recv_idle_on = 1'b1;
    send_req(OP_CLEAR, 0, 0, '0);
    hold_off_len = HOLD_OFF_LEN;                   // block fills up and stalls input
    repeat (15) store_record(1, MAX_RECORD_WORDS);
    send_req(OP_BEGIN, 2, MAX_RECORD_WORDS, '0);   // tail too short, head taken
    store_record(2, 47);                           // ends one word before the end
    send_req(OP_BEGIN, 4, 1, '0);                  // one word left, needs two
    repeat (3) send_req(OP_FETCH, 1, 0, '0);       // read pointer moves up
    store_record(3, 20);                           // wraps to word 0
    store_record(5, MAX_RECORD_WORDS);
    store_record(5, MAX_RECORD_WORDS);
    send_req(OP_BEGIN, 6, MAX_RECORD_WORDS, '0);   // wrapped and out of room
    send_req(OP_FETCH, 3, 0, '0);                  // walk passes the wrap mark
    send_req(OP_FETCH, 2, 0, '0);
    send_req(OP_INVAL, 1, 0, '0);
    send_req(OP_INVAL, 5, 0, '0);
    send_req(OP_FETCH, 1, 0, '0);
  endtask

  // ring read out while a store is still open keeps the write pointer; ends
  // with the pointers near the end of the ring for the random part
  task automatic test_drain_with_open_store();
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    send_req(OP_CLEAR, 0, 0, '0);
    store_record(4, 2);
    send_req(OP_BEGIN, 3, 3, '0);
    send_req(OP_STORE, 0, 0, $urandom);
    send_req(OP_FETCH, 4, 0, '0);
    repeat (2) send_req(OP_STORE, 0, 0, $urandom);
    send_req(OP_FETCH, 3, 0, '0);
    send_idle_on = 1'b0;
    repeat (14) store_record(NUM_CHANNELS - 1, MAX_RECORD_WORDS - 1);
    send_req(OP_BEGIN, NUM_CHANNELS - 3, 3, '0);
    send_req(OP_STORE, 0, 0, $urandom);
    send_req(OP_INVAL, NUM_CHANNELS - 1, 0, '0);
    repeat (2) send_req(OP_STORE, 0, 0, $urandom);
  endtask

  // mostly complete records with random content, mixed with fetches,
  // invalidates and broken or unknown requests
  task automatic test_random_traffic();
    int unsigned first, n, d;
    first = reqs_sent;
    while (reqs_sent - first < RANDOM_REQS) begin
      // a stretch with no idling on either side
      n = reqs_sent - first;
      send_idle_on = !(n >= 80 && n < 120);
      recv_idle_on = send_idle_on;
      d = $urandom_range(0, 99);
      if (open_left != 0 && d < 70) begin
        n = open_left;
        if ($urandom_range(0, 9) == 0) n = $urandom_range(1, n);
        repeat (n) send_req(OP_STORE, $urandom, $urandom, $urandom);
      end else begin
        d = $urandom_range(0, 99);
        if (d < 40) begin
          send_req(OP_BEGIN, pick_channel(), pick_len(), $urandom);
        end else if (d < 70) begin
          send_req(OP_FETCH, pick_channel(), $urandom, $urandom);
        end else if (d < 80) begin
          send_req(OP_INVAL, pick_channel(), $urandom, $urandom);
        end else if (d < 86) begin
          send_req(OP_STORE, $urandom, $urandom, $urandom);
        end else if (d < 89) begin
          send_req(OP_CLEAR, $urandom, $urandom, $urandom);
        end else if (d < 94) begin
          send_req($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI), $urandom, $urandom, $urandom);
        end else begin
          // zero or oversize length
          send_req(OP_BEGIN, $urandom, ($urandom_range(0, 1) == 0) ? '0 :
                   len_t'($urandom_range(MAX_RECORD_WORDS + 1, (1 << LEN_W) - 1)), $urandom);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------

  initial begin : run
    fail_count          = 0;
    reqs_sent           = 0;
    quiet_cycles        = 0;
    hold_off_len        = 0;
    send_idle_on        = 1'b0;
    recv_idle_on        = 1'b0;
    rd_ptr              = 0;
    wr_ptr              = 0;
    wrap_mark           = 0;
    open_left           = 0;
    req_if.valid        = 1'b0;
    req_if.operation    = OP_BEGIN;
    req_if.channel      = '0;
    req_if.length_words = '0;
    req_if.data_word    = '0;
    rst_ni              = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_single_ops();
    test_fill_and_wrap();
    test_drain_with_open_store();
    test_random_traffic();

    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (ring_answers_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** multichannel_record_ring_buffer: PASSED **");
    end else begin
      $display("** multichannel_record_ring_buffer: FAILED **");
    end
    $finish;
  end

endmodule
